FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lasu_pkg.sv
package lasu_pkg;

    localparam int CONNECTIONS_DEF = 1024;
    localparam int SLOTS_DEF       = 15;

    localparam int FUNC_W  = 2;
    localparam int CONN_W  = 10;
    localparam int RV_W    = 16;
    localparam int SLOT_W  = 4;
    localparam int WEIGHT_W = 9;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W  = $clog2(RV_W);

    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'h55;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 8'd1;
    localparam logic [COUNT_W-1:0] HIGH_RESET  = 8'd255;
    localparam logic [COUNT_W-1:0] LOW_RESET   = 8'd80;

    localparam logic [FUNC_W-1:0] FUNC_SELECT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REWARD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PENALIZE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RENORM_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RENORM_LOW  = 1'b1;

    typedef logic signed [WEIGHT_W-1:0] t_weight;

    // Fixed slot weights; the last slot (only with sixteen slots) repeats +128.
    function automatic t_weight weight_of(input logic [SLOT_W-1:0] slot);
        t_weight w;
        case (slot)
            4'd0:    w = -9'sd128;
            4'd1:    w = -9'sd64;
            4'd2:    w = -9'sd32;
            4'd3:    w = -9'sd16;
            4'd4:    w = -9'sd8;
            4'd5:    w = -9'sd4;
            4'd6:    w = -9'sd2;
            4'd7:    w = 9'sd0;
            4'd8:    w = 9'sd2;
            4'd9:    w = 9'sd4;
            4'd10:   w = 9'sd8;
            4'd11:   w = 9'sd16;
            4'd12:   w = 9'sd32;
            4'd13:   w = 9'sd64;
            4'd14:   w = 9'sd128;
            default: w = 9'sd128;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/learning_automaton_slot_select_unit.sv
// Learning-automaton slot selector. Each connection owns SLOTS 8-bit counts
// (one RAM row per connection) and the slot it chose last (a second RAM).
// func 0 (select) sums the row, reduces random_value modulo that sum and
// walks the counts to pick a slot; func 1/2 (reward/penalize) moves the
// chosen slot's count by +1/-1, held within 1..255, then halves every count
// (rounding up) when the largest is >= renorm_high, or doubles every count
// (saturating at 255) when the largest is < renorm_low. Func 3 changes
// nothing. Every item returns one result: the chosen slot and its weight.
// conn_index is reduced modulo CONNECTIONS. After reset the block runs a
// clearing pass of all CONNECTIONS rows (counts to 0x55, chosen slot 0) with
// o_in_stall high; register writes are taken during it. Items are processed
// one at a time by a small sequencer around one add/subtract/compare unit
// and one restoring shift-subtract modulo unit (one quotient bit per cycle).
// Select runs a sum pass over the slots, the 16-bit modulo and a walk that
// stops at the chosen slot; reward and penalize run an update, a maximum
// pass over the slots and the renorm step; func 3 goes straight to the
// result. When CONNECTIONS < 1024 the modulo unit reduces conn_index first.
// A finished result waits in the output register, so the next item can be
// taken meanwhile.
`include "assert_macros.svh"

module learning_automaton_slot_select_unit #(
    parameter int CONNECTIONS = lasu_pkg::CONNECTIONS_DEF,
    parameter int SLOTS       = lasu_pkg::SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [lasu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lasu_pkg::COUNT_W-1:0]       i_cfg_wdata,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lasu_pkg::FUNC_W-1:0]        i_func,
    input  logic [lasu_pkg::CONN_W-1:0]        i_conn_index,
    input  logic [lasu_pkg::RV_W-1:0]          i_random_value,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lasu_pkg::SLOT_W-1:0]        o_slot,
    output logic signed [lasu_pkg::WEIGHT_W-1:0] o_weight
);

    localparam int AW      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int KW      = $clog2(SLOTS);
    localparam int CW      = lasu_pkg::COUNT_W;
    localparam int ROW_W   = SLOTS * CW;
    localparam int SUM_W   = $clog2(SLOTS * 255 + 1);
    localparam int D_W     = (SUM_W > lasu_pkg::CONN_W) ? SUM_W : lasu_pkg::CONN_W;
    localparam bit NEED_CMOD = CONNECTIONS < (1 << lasu_pkg::CONN_W);
    localparam int CMOD_DIV  = NEED_CMOD ? CONNECTIONS : 1;

    // sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CMOD  = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_LOAD  = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_MOD   = 4'd6;
    localparam logic [3:0] ST_WALK  = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;
    localparam logic [3:0] ST_MAX   = 4'd9;
    localparam logic [3:0] ST_REN   = 4'd10;
    localparam logic [3:0] ST_WB    = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    localparam logic [KW-1:0]                  LAST_SLOT = KW'(SLOTS - 1);
    localparam logic [lasu_pkg::STEP_W-1:0]    LAST_STEP = lasu_pkg::STEP_W'(lasu_pkg::RV_W - 1);
    localparam logic [AW-1:0]                  LAST_CONN = AW'(CONNECTIONS - 1);

    // control state
    logic [3:0]                    r_state, n_state;
    logic [AW-1:0]                 r_clr, n_clr;
    logic [lasu_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic                          r_out_valid;
    logic [CW-1:0]                 r_renorm_high;
    logic [CW-1:0]                 r_renorm_low;

    // working payload
    logic [lasu_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [lasu_pkg::CONN_W-1:0]   r_conn, n_conn;
    logic [lasu_pkg::RV_W-1:0]     r_rv, n_rv;
    logic [lasu_pkg::RV_W-1:0]     r_dvd, n_dvd;
    logic [D_W-1:0]                r_div, n_div;
    logic [D_W:0]                  r_rem, n_rem;
    logic [SUM_W-1:0]              r_acc, n_acc;
    logic [lasu_pkg::SLOT_W-1:0]   r_chosen, n_chosen;
    logic [CW-1:0]                 r_row [SLOTS];
    logic [CW-1:0]                 n_row [SLOTS];
    logic [lasu_pkg::SLOT_W-1:0]   r_out_slot;
    lasu_pkg::t_weight             r_out_weight;

    // RAM side
    logic                          w_ram_we;
    logic [AW-1:0]                 w_ram_waddr;
    logic [AW-1:0]                 w_conn_addr;
    logic [ROW_W-1:0]              w_row_wdata;
    logic [ROW_W-1:0]              w_row_rdata;
    logic [lasu_pkg::SLOT_W-1:0]   w_chosen_wdata;
    logic [lasu_pkg::SLOT_W-1:0]   w_chosen_rdata;
    logic [ROW_W-1:0]              w_row_packed;

    // shared units
    logic [CW-1:0]                 w_cnt_k;
    logic [SUM_W-1:0]              w_cnt_ext;
    logic [SUM_W-1:0]              w_alu_sum;
    logic [SUM_W-1:0]              w_alu_diff;
    logic                          w_alu_le;
    logic [D_W:0]                  w_mod_shift;
    logic                          w_mod_ge;
    logic [D_W:0]                  w_mod_rem;
    logic [KW-1:0]                 w_tgt;
    logic [CW-1:0]                 w_tgt_cnt;
    logic [CW-1:0]                 w_tgt_new;
    logic                          w_out_load;
    logic                          w_row_nonzero;

    assign w_conn_addr = AW'(r_conn);

    lasu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CONNECTIONS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_conn_addr),
        .o_rdata (w_row_rdata)
    );

    lasu_ram #(
        .WIDTH (lasu_pkg::SLOT_W),
        .DEPTH (CONNECTIONS)
    ) u_chosen_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_chosen_wdata),
        .i_raddr (w_conn_addr),
        .o_rdata (w_chosen_rdata)
    );

    always_comb begin
        w_row_nonzero = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            w_row_packed[k*CW +: CW] = r_row[k];
            if (r_row[k] == '0) begin
                w_row_nonzero = 1'b0;
            end
        end
    end

    // clearing pass writes reset rows, write-back writes the working row
    assign w_ram_waddr    = (r_state == ST_CLEAR) ? r_clr : w_conn_addr;
    assign w_row_wdata    = (r_state == ST_CLEAR) ? {SLOTS{lasu_pkg::COUNT_RESET}}
                                                  : w_row_packed;
    assign w_chosen_wdata = (r_state == ST_CLEAR) ? '0 : r_chosen;

    // add / subtract / compare unit: accumulator against count[k]
    assign w_cnt_k    = r_row[r_cnt[KW-1:0]];
    assign w_cnt_ext  = SUM_W'(w_cnt_k);
    assign w_alu_sum  = r_acc + w_cnt_ext;
    assign w_alu_diff = r_acc - w_cnt_ext;
    assign w_alu_le   = (r_acc <= w_cnt_ext);

    // one restoring modulo step
    assign w_mod_shift = {r_rem[D_W-1:0], r_dvd[lasu_pkg::RV_W-1]};
    assign w_mod_ge    = (w_mod_shift >= {1'b0, r_div});
    assign w_mod_rem   = w_mod_ge ? (w_mod_shift - {1'b0, r_div}) : w_mod_shift;

    // feedback target; an out-of-range chosen slot falls back to slot 0
    assign w_tgt = ((lasu_pkg::SLOT_W + 1)'(r_chosen) >= (lasu_pkg::SLOT_W + 1)'(SLOTS))
                   ? '0 : r_chosen[KW-1:0];
    assign w_tgt_cnt = r_row[w_tgt];

    always_comb begin
        if (r_func == lasu_pkg::FUNC_REWARD) begin
            w_tgt_new = (w_tgt_cnt == lasu_pkg::COUNT_MAX) ? w_tgt_cnt : w_tgt_cnt + 1'b1;
        end else begin
            w_tgt_new = (w_tgt_cnt <= lasu_pkg::COUNT_MIN) ? lasu_pkg::COUNT_MIN
                                                           : w_tgt_cnt - 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cnt      = r_cnt;
        n_func     = r_func;
        n_conn     = r_conn;
        n_rv       = r_rv;
        n_dvd      = r_dvd;
        n_div      = r_div;
        n_rem      = r_rem;
        n_acc      = r_acc;
        n_chosen   = r_chosen;
        n_row      = r_row;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                w_ram_we = 1'b1;
                if (r_clr == LAST_CONN) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_func;
                    n_conn = i_conn_index;
                    n_rv   = i_random_value;
                    if (NEED_CMOD) begin
                        n_dvd   = lasu_pkg::RV_W'(i_conn_index);
                        n_div   = D_W'(CMOD_DIV);
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_CMOD;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_CMOD: begin
                n_rem = w_mod_rem;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_conn  = lasu_pkg::CONN_W'(w_mod_rem);
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                for (int k = 0; k < SLOTS; k++) begin
                    n_row[k] = w_row_rdata[k*CW +: CW];
                end
                n_chosen = w_chosen_rdata;
                n_cnt    = '0;
                n_acc    = '0;
                case (r_func)
                    lasu_pkg::FUNC_SELECT:   n_state = ST_SUM;
                    lasu_pkg::FUNC_REWARD:   n_state = ST_UPD;
                    lasu_pkg::FUNC_PENALIZE: n_state = ST_UPD;
                    default:                 n_state = ST_FIN;
                endcase
            end
            ST_SUM: begin
                n_acc = w_alu_sum;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[KW-1:0] == LAST_SLOT) begin
                    n_div   = D_W'(w_alu_sum);
                    n_dvd   = r_rv;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                n_rem = w_mod_rem;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    // empty row: remainder taken as zero
                    n_acc   = (r_div == '0) ? '0 : SUM_W'(w_mod_rem);
                    n_cnt   = '0;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_alu_le) begin
                    n_chosen = r_cnt;
                    n_state  = ST_WB;
                end else begin
                    n_acc = w_alu_diff;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt[KW-1:0] == LAST_SLOT) begin
                        n_state = ST_WB;
                    end
                end
            end
            ST_UPD: begin
                n_row[w_tgt] = w_tgt_new;
                n_acc        = '0;
                n_cnt        = '0;
                n_state      = ST_MAX;
            end
            ST_MAX: begin
                if (w_alu_le) begin
                    n_acc = w_cnt_ext;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[KW-1:0] == LAST_SLOT) begin
                    n_state = ST_REN;
                end
            end
            ST_REN: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (r_acc >= SUM_W'(r_renorm_high)) begin
                        n_row[k] = CW'(({1'b0, r_row[k]} + 9'd1) >> 1);
                    end else if (r_acc < SUM_W'(r_renorm_low)) begin
                        n_row[k] = r_row[k][CW-1] ? lasu_pkg::COUNT_MAX : (r_row[k] << 1);
                    end
                end
                n_state = ST_WB;
            end
            ST_WB: begin
                w_ram_we = 1'b1;
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_renorm_high <= lasu_pkg::HIGH_RESET;
            r_renorm_low  <= lasu_pkg::LOW_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lasu_pkg::REG_RENORM_HIGH: r_renorm_high <= i_cfg_wdata;
                    lasu_pkg::REG_RENORM_LOW:  r_renorm_low  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_conn   <= n_conn;
        r_rv     <= n_rv;
        r_dvd    <= n_dvd;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_chosen <= n_chosen;
        r_row    <= n_row;
        if (w_out_load) begin
            r_out_slot   <= r_chosen;
            r_out_weight <= lasu_pkg::weight_of(r_chosen);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_weight    = r_out_weight;

    // remainder entering the walk is below the row sum
    `ASSERT_IMPLIES(a_walk_rem, i_clk, i_rst_n, (r_state == ST_WALK && r_cnt == '0), (D_W'(r_acc) < r_div || r_div == '0), "walk remainder not below row sum")
    // a reported slot is always one of the row's slots
    `ASSERT_IMPLIES(a_slot_range, i_clk, i_rst_n, (r_state == ST_FIN), ((lasu_pkg::SLOT_W + 1)'(r_chosen) < (lasu_pkg::SLOT_W + 1)'(SLOTS)), "chosen slot out of range")
    // no count of zero is ever written back
    `ASSERT_IMPLIES(a_row_nonzero, i_clk, i_rst_n, (r_state == ST_WB), w_row_nonzero, "zero count in written row")
    // clearing pass does not end early
    `ASSERT_NEXT(a_clear_len, i_clk, i_rst_n, (r_state == ST_CLEAR && r_clr != LAST_CONN), (r_state == ST_CLEAR), "clearing pass left early")

endmodule

FILE: rtl/lasu_ram.sv
module lasu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lasu_pkg::*;

    localparam int NCONN = CONNECTIONS_DEF;
    localparam int NSLOT = SLOTS_DEF;

    // func code with no operation behind it: the block only reports the current slot
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    // extra wait after draining, with margin over the slowest select
    localparam int SETTLE_CYCLES = 60;

    // fixed slot weights, own copy (slot 15 only exists with sixteen slots)
    localparam t_weight SLOT_WEIGHT [16] = '{
        -9'sd128, -9'sd64, -9'sd32, -9'sd16, -9'sd8, -9'sd4, -9'sd2, 9'sd0,
        9'sd2, 9'sd4, 9'sd8, 9'sd16, 9'sd32, 9'sd64, 9'sd128, 9'sd128
    };

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_weight           weight;
    } t_choice;

    // one directed item; known rows carry an expected choice typed in by hand
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CONN_W-1:0] conn;
        logic [RV_W-1:0]   rv;
        bit                known;
        logic [SLOT_W-1:0] slot;
        t_weight           weight;
    } t_probe;

    // Directed items, run with the reset thresholds (high 255, low 80).
    // Fresh rows hold fifteen counts of 85, sum 1275.
    localparam int N_PROBES = 19;
    localparam t_probe PROBES [N_PROBES] = '{
        // remainder zero on a fresh row: first slot
        '{FUNC_SELECT,   10'd0,    16'h0000, 1'b1, 4'd0,  -9'sd128},
        // unused func code: nothing moves, current slot reported
        '{FUNC_NOP,      10'd0,    16'hFFFF, 1'b1, 4'd0,  -9'sd128},
        // 1274 = 14*85 + 84: walk runs to the last slot
        '{FUNC_SELECT,   10'd1023, 16'd1274, 1'b1, 4'd14, 9'sd128},
        // 65535 mod 1275 = 510 = 6*85: lands exactly on slot 5
        '{FUNC_SELECT,   10'd1,    16'hFFFF, 1'b1, 4'd5,  -9'sd4},
        '{FUNC_SELECT,   10'd2,    16'd86,   1'b1, 4'd1,  -9'sd64},
        // remainder equal to the first count stops at slot 0
        '{FUNC_SELECT,   10'd3,    16'd85,   1'b1, 4'd0,  -9'sd128},
        // random value equal to the sum wraps to zero
        '{FUNC_SELECT,   10'd4,    16'd1275, 1'b1, 4'd0,  -9'sd128},
        // feedback without renorm (largest stays within 80..254)
        '{FUNC_REWARD,   10'd1023, 16'h0000, 1'b1, 4'd14, 9'sd128},
        '{FUNC_PENALIZE, 10'd1023, 16'hFFFF, 1'b1, 4'd14, 9'sd128},
        '{FUNC_PENALIZE, 10'd1023, 16'h0000, 1'b1, 4'd14, 9'sd128},
        '{FUNC_REWARD,   10'd0,    16'h0000, 1'b1, 4'd0,  -9'sd128},
        // penalty on a row that never selected: slot 0
        '{FUNC_PENALIZE, 10'd5,    16'h0000, 1'b1, 4'd0,  -9'sd128},
        '{FUNC_SELECT,   10'd1023, 16'h8000, 1'b0, 4'd0,  9'sd0},
        '{FUNC_SELECT,   10'h2AA,  16'h5555, 1'b0, 4'd0,  9'sd0},
        '{FUNC_SELECT,   10'h155,  16'hAAAA, 1'b0, 4'd0,  9'sd0},
        '{FUNC_REWARD,   10'h155,  16'h1234, 1'b0, 4'd0,  9'sd0},
        '{FUNC_NOP,      10'd1023, 16'h0000, 1'b0, 4'd0,  9'sd0},
        '{FUNC_PENALIZE, 10'd2,    16'h0000, 1'b1, 4'd1,  -9'sd64},
        '{FUNC_SELECT,   10'd1,    16'h00FF, 1'b0, 4'd0,  9'sd0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [COUNT_W-1:0]         i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [FUNC_W-1:0]          i_func;
    logic [CONN_W-1:0]          i_conn_index;
    logic [RV_W-1:0]            i_random_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [SLOT_W-1:0]          o_slot;
    logic signed [WEIGHT_W-1:0] o_weight;

    learning_automaton_slot_select_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_conn_index   (i_conn_index),
        .i_random_value (i_random_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot         (o_slot),
        .o_weight       (o_weight)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the selector: counts per connection, last chosen slot,
    // and the two renorm thresholds.
    logic [COUNT_W-1:0] row_count [NCONN][NSLOT];
    logic [SLOT_W-1:0]  last_slot [NCONN];
    logic [COUNT_W-1:0] thr_high;
    logic [COUNT_W-1:0] thr_low;

    t_choice pending_choices [$];
    int      mismatches = 0;
    int      burst_left = 0;

    // Advance the shadow state by one item and return the choice it reports.
    task automatic predict_choice(input logic [FUNC_W-1:0] f, input logic [CONN_W-1:0] conn,
                                  input logic [RV_W-1:0] rv, output t_choice res);
        int unsigned c;
        int unsigned total;
        int unsigned top;
        int unsigned t;
        int unsigned d;
        int          rem;
        int          v;
        c = conn % NCONN;
        case (f)
            FUNC_SELECT: begin
                total = 0;
                for (int k = 0; k < NSLOT; k++) total += row_count[c][k];
                // an all-zero row cannot happen, but would pick slot 0
                rem = (total != 0) ? int'(rv % total) : 0;
                for (int k = 0; k < NSLOT; k++) begin
                    rem -= int'(row_count[c][k]);
                    if (rem <= 0) begin
                        last_slot[c] = SLOT_W'(k);
                        break;
                    end
                end
            end
            FUNC_REWARD, FUNC_PENALIZE: begin
                t = last_slot[c];
                if (t >= NSLOT) t = 0;
                v = int'(row_count[c][t]) + ((f == FUNC_REWARD) ? 1 : -1);
                // held within 1..255 (saturates instead of wrapping)
                if (v < int'(COUNT_MIN)) v = int'(COUNT_MIN);
                if (v > int'(COUNT_MAX)) v = int'(COUNT_MAX);
                row_count[c][t] = COUNT_W'(v);
                top = 0;
                for (int k = 0; k < NSLOT; k++)
                    if (row_count[c][k] > top) top = row_count[c][k];
                if (top >= thr_high) begin
                    for (int k = 0; k < NSLOT; k++)
                        row_count[c][k] = COUNT_W'((int'(row_count[c][k]) + 1) / 2);
                end else if (top < thr_low) begin
                    for (int k = 0; k < NSLOT; k++) begin
                        d = 2 * row_count[c][k];
                        row_count[c][k] = (d > COUNT_MAX) ? COUNT_MAX : COUNT_W'(d);
                    end
                end
            end
            default: ;
        endcase
        res.slot   = last_slot[c];
        res.weight = SLOT_WEIGHT[last_slot[c]];
    endtask

    // Offer one item; the sender runs in bursts with random gaps between them.
    // Valid stays high across a burst, so it is never dropped and raised in one step.
    task automatic offer_item(input logic [FUNC_W-1:0] f, input logic [CONN_W-1:0] conn,
                              input logic [RV_W-1:0] rv, input bit known,
                              input logic [SLOT_W-1:0] k_slot, input t_weight k_weight);
        int      gap;
        t_choice res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_conn_index   <= conn;
        i_random_value <= rv;
        do @(posedge i_clk); while (o_in_stall);
        predict_choice(f, conn, rv, res);
        if (known) begin
            res.slot   = k_slot;
            res.weight = k_weight;
        end
        pending_choices.push_back(res);
    endtask

    // Drop valid, let every result come back, then let the block go quiet.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_RENORM_HIGH) thr_high = val;
        else                        thr_low  = val;
    endtask

    // One random phase at a fixed threshold setting. Mostly well-formed runs:
    // a select on a small pool of connections followed by a string of
    // rewards/penalties with a random bias; some long one-sided strings push
    // counts to the clamp at 1 or into saturation. About a tenth is noise
    // (any func code, any connection).
    task automatic run_phase(input logic [COUNT_W-1:0] hi, input logic [COUNT_W-1:0] lo,
                             input int n_items);
        logic [CONN_W-1:0] pool [8];
        logic [CONN_W-1:0] c;
        logic [FUNC_W-1:0] f;
        int                done;
        int                len;
        int                bias;
        drain_results();
        write_reg(REG_RENORM_HIGH, hi);
        write_reg(REG_RENORM_LOW, lo);
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 8; i++) pool[i] = CONN_W'($urandom);
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 10) begin
                offer_item(FUNC_W'($urandom), CONN_W'($urandom), RV_W'($urandom),
                           1'b0, '0, '0);
                done++;
            end else begin
                c = pool[$urandom_range(0, 7)];
                offer_item(FUNC_SELECT, c, RV_W'($urandom), 1'b0, '0, '0);
                done++;
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 30);
                bias = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 100)
                                                   : $urandom_range(0, 100);
                for (int i = 0; i < len && done < n_items; i++) begin
                    if ($urandom_range(0, 99) < 3)    f = FUNC_NOP;
                    else if ($urandom_range(0, 99) < bias) f = FUNC_REWARD;
                    else                              f = FUNC_PENALIZE;
                    offer_item(f, c, RV_W'($urandom), 1'b0, '0, '0);
                    done++;
                end
            end
        end
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_choice want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_choices.size() == 0) begin
                $error("unexpected result: slot %0d weight %0d", o_slot, o_weight);
                mismatches++;
            end else begin
                want = pending_choices.pop_front();
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, o_slot);
                    mismatches++;
                end
                if (o_weight !== want.weight) begin
                    $error("weight: expected %0d, actual %0d", want.weight, o_weight);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: runs of random stall density, some with no stall at all.
    // Every so often it holds off for a long stretch while the sender keeps
    // offering, so the output register fills and the block stalls its input.
    initial begin : receiver
        int rx_cycles;
        int next_hold;
        int run;
        int odds;
        rx_cycles   = 0;
        next_hold   = 5000;
        i_out_stall = 1'b0;
        forever begin
            run  = $urandom_range(5, 80);
            odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
            repeat (run) begin
                @(negedge i_clk);
                rx_cycles++;
                i_out_stall <= ($urandom_range(0, 99) < odds);
            end
            if (rx_cycles >= next_hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                rx_cycles += 401;
                next_hold = rx_cycles + 30000;
            end
        end
    end

    // Hard stop in case the run hangs.
    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_SELECT;
        i_conn_index   = '0;
        i_random_value = '0;
        thr_high       = HIGH_RESET;
        thr_low        = LOW_RESET;
        for (int c = 0; c < NCONN; c++) begin
            last_slot[c] = '0;
            for (int k = 0; k < NSLOT; k++) row_count[c][k] = COUNT_RESET;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; the clearing pass after reset shows up as input stall
        for (int i = 0; i < N_PROBES; i++)
            offer_item(PROBES[i].func, PROBES[i].conn, PROBES[i].rv, PROBES[i].known,
                       PROBES[i].slot, PROBES[i].weight);

        // threshold settings: the reset pair, then extremes: always halve, double until
        // saturated, never double (lets penalties reach the floor), halve beats double
        run_phase(8'd255, 8'd80,  240);
        run_phase(8'd1,   8'd1,   230);
        run_phase(8'd255, 8'd255, 250);
        run_phase(8'd255, 8'd1,   260);
        run_phase(8'd1,   8'd255, 220);
        run_phase(8'd200, 8'd120, 240);
        run_phase(COUNT_W'($urandom_range(1, 255)), COUNT_W'($urandom_range(1, 255)), 240);

        drain_results();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
